// ===== rtl/qdt_pkg.sv =====
// Shared types, constants and register codes of the quoted delimiter tokenizer.
`default_nettype none

package qdt_pkg;

   // Defaults for the top-level parameters.
   localparam int DELIMITER_SLOTS_DEFAULT = 4;

   // Fixed field widths.
   localparam int BYTE_W     = 8;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 8;
   localparam int COUNT_W    = 3;
   localparam int TUSER_W    = 3;

   // Bit positions in the result channel's tuser.
   localparam int TUSER_BYTE_VALID  = 0;
   localparam int TUSER_TOKEN_END   = 1;
   localparam int TUSER_STRING_DONE = 2;

   // Special bytes.
   localparam logic [BYTE_W-1:0] CH_QUOTE     = 8'h22;
   localparam logic [BYTE_W-1:0] CH_BACKSLASH = 8'h5C;

   // Delimiter slots that have a register behind them.
   localparam int SLOT_REGS = 4;
   localparam logic [BYTE_W-1:0] SLOT_RESET [SLOT_REGS] = '{8'd32, 8'd44, 8'd9, 8'd59};

   localparam logic [COUNT_W-1:0] COUNT_RESET   = 3'd1;
   localparam logic               HONOUR_RESET  = 1'b1;
   localparam logic               ALLOW_RESET   = 1'b0;

   // Register indexes on the configuration port.
   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_DELIM_COUNT = 3'd0,
      CSR_DELIM_A     = 3'd1,
      CSR_DELIM_B     = 3'd2,
      CSR_DELIM_C     = 3'd3,
      CSR_DELIM_D     = 3'd4,
      CSR_HONOUR      = 3'd5,
      CSR_ALLOW_EMPTY = 3'd6
   } csr_index_type;

   // At most this many results come from one input item.
   localparam int MAX_RESULTS = 3;
   localparam int RUN_CNT_W   = 2;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              byte_valid;
      logic              token_end;
      logic              string_done;
      logic              run_last;
   } result_type;

   typedef struct packed {
      result_type [MAX_RESULTS-1:0] res;
      logic [RUN_CNT_W-1:0]         cnt;
   } run_type;

   typedef struct packed {
      logic in_quotes;
      logic pending_backslash;
      logic token_has_bytes;
   } tok_state_type;

   typedef struct packed {
      logic [COUNT_W-1:0] delimiter_count;
      logic               honour_quotes;
      logic               allow_empty;
   } cfg_flags_type;

endpackage : qdt_pkg

`default_nettype wire

// ===== rtl/qdt_step.sv =====
// Per-byte tokenizer step: results of one input byte and the next token state.
`default_nettype none

module qdt_step #(
   parameter int DELIMITER_SLOTS = qdt_pkg::DELIMITER_SLOTS_DEFAULT
) (
   input  wire logic [qdt_pkg::BYTE_W-1:0] ch_i,
   input  wire logic                       final_i,
   input  wire logic [qdt_pkg::BYTE_W-1:0] slot_i [DELIMITER_SLOTS],
   input  wire qdt_pkg::cfg_flags_type     cfg_i,
   input  wire qdt_pkg::tok_state_type     state_i,
   output qdt_pkg::tok_state_type          state_o,
   output qdt_pkg::run_type                run_o
);
   import qdt_pkg::*;

   logic hit;

   // Active slots run from zero upward; a count above the slots saturates.
   always_comb begin
      hit = 1'b0;
      for (int i = 0; i < DELIMITER_SLOTS; i++) begin
         if ((int'(cfg_i.delimiter_count) > i) && (slot_i[i] == ch_i)) begin
            hit = 1'b1;
         end
      end
   end

   always_comb begin
      tok_state_type         nxt;
      logic [RUN_CNT_W-1:0]  k;
      logic                  closing;
      logic                  done;
      run_type               run;

      nxt     = state_i;
      k       = '0;
      closing = final_i;
      done    = 1'b0;
      run     = '0;

      // A held backslash is either swallowed by an escaped quote or emitted.
      if (state_i.pending_backslash) begin
         nxt.pending_backslash = 1'b0;
         nxt.token_has_bytes   = 1'b1;
         run.res[k].byte_valid = 1'b1;
         if (ch_i == CH_QUOTE) begin
            run.res[k].out_byte = CH_QUOTE;
            done                = 1'b1;
         end else begin
            run.res[k].out_byte = CH_BACKSLASH;
         end
         k = k + 2'd1;
      end

      if (!done) begin
         if (!state_i.in_quotes && hit) begin
            if (nxt.token_has_bytes || cfg_i.allow_empty) begin
               run.res[k].token_end   = 1'b1;
               run.res[k].string_done = final_i;
               k       = k + 2'd1;
               closing = 1'b0;
            end else if (final_i) begin
               run.res[k].string_done = 1'b1;
               k       = k + 2'd1;
               closing = 1'b0;
            end
            nxt.token_has_bytes = 1'b0;
         end else if (cfg_i.honour_quotes && (ch_i == CH_QUOTE)) begin
            nxt.in_quotes = !state_i.in_quotes;
         end else if (state_i.in_quotes && (ch_i == CH_BACKSLASH) && !final_i) begin
            nxt.pending_backslash = 1'b1;
         end else begin
            run.res[k].out_byte   = ch_i;
            run.res[k].byte_valid = 1'b1;
            nxt.token_has_bytes   = 1'b1;
            k = k + 2'd1;
         end
      end

      if (closing) begin
         run.res[k].token_end   = nxt.token_has_bytes || cfg_i.allow_empty;
         run.res[k].string_done = 1'b1;
         k = k + 2'd1;
      end

      if (k != '0) begin
         run.res[k - 2'd1].run_last = 1'b1;
      end
      run.cnt = k;

      // Nothing carries over from one string to the next.
      if (final_i) begin
         nxt = '0;
      end

      state_o = nxt;
      run_o   = run;
   end

endmodule : qdt_step

`default_nettype wire

// ===== rtl/qdt_result_buf.sv =====
// Result register: holds one item's results, handing out one per cycle while ready.
`default_nettype none

module qdt_result_buf (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       load_i,
   input  wire qdt_pkg::run_type           run_i,
   output logic                            free_o,
   output logic                            rsp_tvalid,
   input  wire logic                       rsp_tready,
   output logic [qdt_pkg::BYTE_W-1:0]      rsp_tdata,
   output logic [qdt_pkg::TUSER_W-1:0]     rsp_tuser,
   output logic                            rsp_tlast
);
   import qdt_pkg::*;

   run_type                run_ff;
   run_type                run_in;
   logic                   valid_ff;
   logic                   valid_in;
   logic [RUN_CNT_W-1:0]   idx_ff;
   logic [RUN_CNT_W-1:0]   idx_in;
   result_type             cur;
   logic                   take;

   assign cur    = run_ff.res[idx_ff];
   assign take   = valid_ff && rsp_tready;
   assign free_o = !valid_ff || (rsp_tready && cur.run_last);

   always_comb begin
      run_in   = run_ff;
      valid_in = valid_ff;
      idx_in   = idx_ff;
      if (load_i) begin
         run_in   = run_i;
         valid_in = 1'b1;
         idx_in   = '0;
      end else if (take) begin
         if (cur.run_last) begin
            valid_in = 1'b0;
         end else begin
            idx_in = idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      run_ff <= run_in;
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   assign rsp_tvalid                   = valid_ff;
   assign rsp_tdata                    = cur.out_byte;
   assign rsp_tuser[TUSER_BYTE_VALID]  = cur.byte_valid;
   assign rsp_tuser[TUSER_TOKEN_END]   = cur.token_end;
   assign rsp_tuser[TUSER_STRING_DONE] = cur.string_done;
   assign rsp_tlast                    = cur.run_last;

endmodule : qdt_result_buf

`default_nettype wire

// ===== rtl/quoted_delimiter_tokenizer_unit.sv =====
// Top level of the quoted delimiter tokenizer: input register, step logic, result register.
`default_nettype none

// Channel  Direction  Payload
// req_     in         tdata = ch[7:0]; tlast = final_byte
// rsp_     out        tdata = out_byte[7:0]; tuser = byte_valid, token_end, string_done
//                     (from bit 0 up); tlast = run_last
// csr_     in         csr_we, csr_addr = register index, csr_wdata = value
//
// Each input item is registered, then stepped into its result run of
// zero to three results, which the result register emits one per cycle while
// rsp_tready is high. A byte giving one result then sustains one item per cycle;
// a run of several results holds the input side until its last result is taken,
// set by the single result port. Items that give no result leave the input
// register once the result register can take a run, and emit nothing.
// Reset is synchronous and active high; it restores the default registers and
// clears the token state. rsp_tready low stalls the result register, and the input
// register still takes one further item while results wait.

module quoted_delimiter_tokenizer_unit #(
   parameter int DELIMITER_SLOTS = qdt_pkg::DELIMITER_SLOTS_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // Input bytes: tdata = ch.
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   input  wire logic [qdt_pkg::BYTE_W-1:0]    req_tdata,
   input  wire logic                          req_tlast,
   // Results: tdata = out_byte; tuser = byte_valid, token_end, string_done.
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   output logic [qdt_pkg::BYTE_W-1:0]         rsp_tdata,
   output logic [qdt_pkg::TUSER_W-1:0]        rsp_tuser,
   output logic                               rsp_tlast,
   // Configuration writes.
   input  wire logic                          csr_we,
   input  wire logic [qdt_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [qdt_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import qdt_pkg::*;

   // Configuration registers.
   logic [COUNT_W-1:0] count_ff;
   logic               honour_ff;
   logic               allow_ff;
   logic [BYTE_W-1:0]  slot_ff [DELIMITER_SLOTS];
   cfg_flags_type      cfg;

   // Input register.
   logic               in_valid_ff;
   logic               in_valid_in;
   logic [BYTE_W-1:0]  in_ch_ff;
   logic               in_fin_ff;
   logic               req_take;
   logic               advance;

   // Token state carried from byte to byte.
   tok_state_type      state_ff;
   tok_state_type      state_in;

   run_type            run;
   logic               buf_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= COUNT_RESET;
         honour_ff <= HONOUR_RESET;
         allow_ff  <= ALLOW_RESET;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_addr))
            CSR_DELIM_COUNT: count_ff  <= csr_wdata[COUNT_W-1:0];
            CSR_HONOUR:      honour_ff <= csr_wdata[0];
            CSR_ALLOW_EMPTY: allow_ff  <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Slots up to the fourth have a register; any beyond it read as zero.
   for (genvar i = 0; i < DELIMITER_SLOTS; i++) begin : g_slot
      if (i < SLOT_REGS) begin : g_reg
         localparam logic [CSR_ADDR_W-1:0] SLOT_ADDR =
            CSR_ADDR_W'(int'(CSR_DELIM_A) + i);
         always_ff @(posedge clock) begin
            if (reset) begin
               slot_ff[i] <= SLOT_RESET[i];
            end else if (csr_we && (csr_addr == SLOT_ADDR)) begin
               slot_ff[i] <= csr_wdata;
            end
         end
      end else begin : g_zero
         assign slot_ff[i] = '0;
      end
   end

   assign cfg.delimiter_count = count_ff;
   assign cfg.honour_quotes   = honour_ff;
   assign cfg.allow_empty     = allow_ff;

   // The input register moves on as soon as the result register can take its run.
   assign advance    = in_valid_ff && buf_free;
   assign req_tready = !in_valid_ff || buf_free;
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_ch_ff  <= req_tdata;
         in_fin_ff <= req_tlast;
      end
      if (reset) begin
         in_valid_ff <= 1'b0;
         state_ff    <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   qdt_step #(
      .DELIMITER_SLOTS (DELIMITER_SLOTS)
   ) u_step (
      .ch_i    (in_ch_ff),
      .final_i (in_fin_ff),
      .slot_i  (slot_ff),
      .cfg_i   (cfg),
      .state_i (state_ff),
      .state_o (state_in),
      .run_o   (run)
   );

   // A run with no results only updates the token state.
   qdt_result_buf u_result_buf (
      .clock      (clock),
      .reset      (reset),
      .load_i     (advance && (run.cnt != '0)),
      .run_i      (run),
      .free_o     (buf_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule : quoted_delimiter_tokenizer_unit

`default_nettype wire

// ===== rtl/qdt_checker.sv =====
// Port-level checks on the tokenizer's result channel, bound to the top level.
`default_nettype none

module qdt_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          rsp_tvalid,
   input wire logic                          rsp_tready,
   input wire logic [qdt_pkg::BYTE_W-1:0]    rsp_tdata,
   input wire logic [qdt_pkg::TUSER_W-1:0]   rsp_tuser,
   input wire logic                          rsp_tlast
);
   import qdt_pkg::*;

   // A stalled result holds.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled result changed");

   // A token byte never also carries a token end or a string end.
   a_byte_not_mark: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[TUSER_BYTE_VALID] |->
         !rsp_tuser[TUSER_TOKEN_END] && !rsp_tuser[TUSER_STRING_DONE])
      else $error("byte result flagged as a mark");

   // A mark carries a zero byte.
   a_mark_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[TUSER_BYTE_VALID] |-> rsp_tdata == '0)
      else $error("mark result with nonzero byte");

   // The closing result of a string ends its run.
   a_done_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[TUSER_STRING_DONE] |-> rsp_tlast)
      else $error("string end not last of its run");

   // No result is shown right after reset.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule : qdt_checker

bind quoted_delimiter_tokenizer_unit qdt_checker u_qdt_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire

// ===== tb/sv/qdt_token_checker.sv =====
// Checker that predicts the tokenizer's result items and compares them on the result channel.
`timescale 1ns / 1ps

module qdt_token_checker #(
   parameter int SLOTS = qdt_pkg::DELIMITER_SLOTS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   input  logic [qdt_pkg::BYTE_W-1:0]      req_tdata,
   input  logic                            req_tlast,
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic [qdt_pkg::BYTE_W-1:0]      rsp_tdata,
   input  logic [qdt_pkg::TUSER_W-1:0]     rsp_tuser,
   input  logic                            rsp_tlast,
   input  logic                            csr_we,
   input  logic [qdt_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  logic [qdt_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output int unsigned                     failures,
   output int unsigned                     results_pending
);
   import qdt_pkg::*;

   // Shadow copy of the configuration registers.
   logic [COUNT_W-1:0] delim_count;
   logic [BYTE_W-1:0]  delim_slot [SLOTS];
   logic               honour_cfg;
   logic               allow_empty_cfg;

   // Shadow copy of the token state.
   logic in_quotes;
   logic bs_pending;
   logic token_open;

   result_type  token_results_due [$];
   int unsigned fail_count = 0;

   assign failures = fail_count;

   function automatic result_type make_result(input logic [BYTE_W-1:0] b, input logic bv,
                                              input logic te, input logic sd);
      result_type r;
      r.out_byte    = b;
      r.byte_valid  = bv;
      r.token_end   = te;
      r.string_done = sd;
      r.run_last    = 1'b0;
      return r;
   endfunction

   // Works out the results that one accepted byte causes and queues them.
   task automatic tokenize_byte(input logic [BYTE_W-1:0] ch, input logic fin);
      result_type run_q [$];
      logic       closing;
      logic       quote_escaped;
      logic       is_delim;
      int         active;
      int         i;
      closing       = fin;
      quote_escaped = 1'b0;
      is_delim      = 1'b0;
      active        = (int'(delim_count) > SLOTS) ? SLOTS : int'(delim_count);
      for (i = 0; i < active; i++)
         if (delim_slot[i] == ch)
            is_delim = 1'b1;

      // A held backslash either becomes a bare quote or is emitted as itself.
      if (bs_pending) begin
         bs_pending = 1'b0;
         token_open = 1'b1;
         if (ch == CH_QUOTE) begin
            run_q.push_back(make_result(CH_QUOTE, 1'b1, 1'b0, 1'b0));
            quote_escaped = 1'b1;
         end else begin
            run_q.push_back(make_result(CH_BACKSLASH, 1'b1, 1'b0, 1'b0));
         end
      end

      if (!quote_escaped) begin
         if (!in_quotes && is_delim) begin
            if (token_open || allow_empty_cfg) begin
               run_q.push_back(make_result('0, 1'b0, 1'b1, fin));
               closing = 1'b0;
            end else if (fin) begin
               run_q.push_back(make_result('0, 1'b0, 1'b0, 1'b1));
               closing = 1'b0;
            end
            token_open = 1'b0;
         end else if (honour_cfg && ch == CH_QUOTE) begin
            in_quotes = !in_quotes;
         end else if (in_quotes && ch == CH_BACKSLASH && !fin) begin
            bs_pending = 1'b1;
         end else begin
            run_q.push_back(make_result(ch, 1'b1, 1'b0, 1'b0));
            token_open = 1'b1;
         end
      end

      if (closing)
         run_q.push_back(make_result('0, 1'b0, token_open || allow_empty_cfg, 1'b1));
      if (fin) begin
         in_quotes  = 1'b0;
         bs_pending = 1'b0;
         token_open = 1'b0;
      end
      if (run_q.size() != 0)
         run_q[run_q.size()-1].run_last = 1'b1;
      foreach (run_q[k])
         token_results_due.push_back(run_q[k]);
   endtask

   task automatic compare_field(input string name, input int unsigned want,
                                input int unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin : monitor
      result_type got;
      result_type want;
      int         slot_idx;
      int         i;
      if (reset) begin
         delim_count     = COUNT_RESET;
         honour_cfg      = HONOUR_RESET;
         allow_empty_cfg = ALLOW_RESET;
         for (i = 0; i < SLOTS; i++)
            delim_slot[i] = (i < SLOT_REGS) ? SLOT_RESET[i] : '0;
         in_quotes  = 1'b0;
         bs_pending = 1'b0;
         token_open = 1'b0;
         token_results_due.delete();
      end else begin
         if (csr_we) begin
            case (csr_addr)
               CSR_DELIM_COUNT: delim_count = csr_wdata[COUNT_W-1:0];
               CSR_DELIM_A, CSR_DELIM_B, CSR_DELIM_C, CSR_DELIM_D: begin
                  slot_idx = int'(csr_addr) - int'(CSR_DELIM_A);
                  if (slot_idx < SLOTS)
                     delim_slot[slot_idx] = csr_wdata;
               end
               CSR_HONOUR:      honour_cfg = csr_wdata[0];
               CSR_ALLOW_EMPTY: allow_empty_cfg = csr_wdata[0];
               default: ;
            endcase
         end

         if (req_tvalid && req_tready)
            tokenize_byte(req_tdata, req_tlast);

         if (rsp_tvalid && rsp_tready) begin
            got.out_byte    = rsp_tdata;
            got.byte_valid  = rsp_tuser[TUSER_BYTE_VALID];
            got.token_end   = rsp_tuser[TUSER_TOKEN_END];
            got.string_done = rsp_tuser[TUSER_STRING_DONE];
            got.run_last    = rsp_tlast;
            if (token_results_due.size() == 0) begin
               $error("result with nothing expected: out_byte 0x%0h tuser 0x%0h tlast %0b",
                      rsp_tdata, rsp_tuser, rsp_tlast);
               fail_count++;
            end else begin
               want = token_results_due.pop_front();
               compare_field("out_byte", 32'(want.out_byte), 32'(got.out_byte));
               compare_field("byte_valid", 32'(want.byte_valid), 32'(got.byte_valid));
               compare_field("token_end", 32'(want.token_end), 32'(got.token_end));
               compare_field("string_done", 32'(want.string_done), 32'(got.string_done));
               compare_field("run_last", 32'(want.run_last), 32'(got.run_last));
            end
         end
      end
      results_pending <= token_results_due.size();
   end

endmodule

// ===== tb/sv/tb_top.sv =====
// Top of the tokenizer testbench: clock, reset, stimulus, receiver and verdict.
`timescale 1ns / 1ps

module tb_top;
   import qdt_pkg::*;

   // Percentage of cycles in which either side sits idle.
   localparam int IDLE_PERCENT   = 12;
   // Length of the one long receiver hold-off that fills the block up.
   localparam int HOLD_CYCLES    = 80;
   // Cycles allowed after the last expected result before reconfiguring or ending;
   // covers items still in the input register that cause no result.
   localparam int DRAIN_CYCLES   = 8;
   // Cycles without any accepted item before the run is declared hung.
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PHASES         = 8;
   localparam int PHASE_ITEMS    = 44;
   // Register index with nothing behind it; writes to it must be ignored.
   localparam logic [CSR_ADDR_W-1:0] CSR_SPARE = 3'd7;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [BYTE_W-1:0]     req_tdata  = '0;   // ch
   logic                  req_tlast  = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [BYTE_W-1:0]     rsp_tdata;         // out_byte
   logic [TUSER_W-1:0]    rsp_tuser;         // byte_valid, token_end, string_done
   logic                  rsp_tlast;
   logic                  csr_we     = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr   = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   int unsigned failures;
   int unsigned results_pending;

   // Stimulus-side knobs shared with the receiver process, and the watchdog's count.
   logic no_idle      = 1'b0;
   logic hold_request = 1'b0;
   logic hold_done    = 1'b0;
   int   hold_left    = 0;
   int   quiet_cycles = 0;

   // Delimiters currently programmed, so random strings can hit them often.
   logic [BYTE_W-1:0] cur_delims [SLOT_REGS] = SLOT_RESET;

   always #1 clock = ~clock;

   quoted_delimiter_tokenizer_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   qdt_token_checker #(
      .SLOTS (DELIMITER_SLOTS_DEFAULT)
   ) token_checker (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tlast       (req_tlast),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tuser       (rsp_tuser),
      .rsp_tlast       (rsp_tlast),
      .csr_we          (csr_we),
      .csr_addr        (csr_addr),
      .csr_wdata       (csr_wdata),
      .failures        (failures),
      .results_pending (results_pending)
   );

   // Receiver. It normally drops ready at random, but once asked it holds ready low
   // for a long stretch, counted here, so the block backs up and stalls its input.
   always @(posedge clock) begin
      if (hold_request && !hold_done) begin
         hold_done  <= 1'b1;
         hold_left  <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= no_idle || ($urandom_range(0, 99) >= IDLE_PERCENT);
      end
   end

   // Watchdog. Any accepted item on either channel restarts the count.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("tb_top: FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Offers one byte and returns at the clock edge that accepts it. Ready is sampled
   // at the falling edge, where it is settled, and applies to the following rising edge.
   task automatic send_item(input logic [BYTE_W-1:0] ch, input logic fin);
      logic ready_seen;
      while (!no_idle && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= ch;
      req_tlast  <= fin;
      do begin
         @(negedge clock);
         ready_seen = req_tready;
         @(posedge clock);
      end while (!ready_seen);
   endtask

   // Stops offering and waits until every predicted result is back, then lets the
   // block settle so that a byte with no result cannot be caught mid-step.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (results_pending != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // One register write; the caller lowers the write enable after its last write.
   task automatic write_reg(input logic [CSR_ADDR_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      @(posedge clock);
   endtask

   // Programs every register. Bits above a register's width carry random values
   // because the block must ignore them.
   task automatic apply_settings(input logic [COUNT_W-1:0] count,
                                 input logic [BYTE_W-1:0] da, input logic [BYTE_W-1:0] db,
                                 input logic [BYTE_W-1:0] dc, input logic [BYTE_W-1:0] dd,
                                 input logic honour, input logic allow);
      logic [CSR_DATA_W-1:0] w;
      w = CSR_DATA_W'($urandom);
      w[COUNT_W-1:0] = count;
      write_reg(CSR_DELIM_COUNT, w);
      write_reg(CSR_DELIM_A, da);
      write_reg(CSR_DELIM_B, db);
      write_reg(CSR_DELIM_C, dc);
      write_reg(CSR_DELIM_D, dd);
      w = CSR_DATA_W'($urandom);
      w[0] = honour;
      write_reg(CSR_HONOUR, w);
      w = CSR_DATA_W'($urandom);
      w[0] = allow;
      write_reg(CSR_ALLOW_EMPTY, w);
      csr_we <= 1'b0;
      cur_delims[0] = da;
      cur_delims[1] = db;
      cur_delims[2] = dc;
      cur_delims[3] = dd;
   endtask

   // Mostly the usual separator characters, sometimes any nonzero byte.
   function automatic logic [BYTE_W-1:0] random_delim();
      case ($urandom_range(0, 7))
         0, 1:    return BYTE_W'($urandom_range(1, 255));
         2:       return " ";
         3:       return ",";
         4:       return ";";
         5:       return ":";
         6:       return "|";
         default: return 8'h09;
      endcase
   endfunction

   // String content weighted toward the bytes that steer the tokenizer: delimiters
   // (also slots beyond the active count), quotes and backslashes.
   function automatic logic [BYTE_W-1:0] pick_byte();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 25)
         return cur_delims[$urandom_range(0, SLOT_REGS - 1)];
      else if (roll < 35)
         return CH_QUOTE;
      else if (roll < 43)
         return CH_BACKSLASH;
      else if (roll < 52)
         return BYTE_W'($urandom_range(1, 255));
      else
         return BYTE_W'(8'h61 + $urandom_range(0, 25));
   endfunction

   initial begin : stimulus
      int phase;
      int sent;
      int len;
      int i;

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part under the reset settings: a single space delimiter, quotes
      // honored, empty tokens suppressed. The first string covers the byte
      // extremes, a doubled delimiter that reports nothing, a quoted delimiter,
      // an escaped quote, a backslash that is not followed by a quote, and a
      // delimiter as the final byte.
      send_item(8'h01, 1'b0);
      send_item(" ", 1'b0);
      send_item(" ", 1'b0);
      send_item(CH_QUOTE, 1'b0);
      send_item("a", 1'b0);
      send_item(" ", 1'b0);
      send_item(CH_BACKSLASH, 1'b0);
      send_item(CH_QUOTE, 1'b0);
      send_item(CH_BACKSLASH, 1'b0);
      send_item("b", 1'b0);
      send_item(CH_QUOTE, 1'b0);
      send_item(8'hFF, 1'b0);
      send_item(" ", 1'b1);
      // A backslash as the final byte inside quotes is an ordinary byte.
      send_item(CH_QUOTE, 1'b0);
      send_item(CH_BACKSLASH, 1'b1);
      // Leave a quoted token open, then turn quotes off mid-string: the quoted
      // mode must persist until the string ends, while a quote is now plain text.
      send_item(CH_QUOTE, 1'b0);
      send_item("q", 1'b0);
      wait_idle();
      write_reg(CSR_SPARE, CSR_DATA_W'($urandom));
      apply_settings(3'd7, " ", ",", 8'h09, ";", 1'b0, 1'b1);
      send_item(" ", 1'b0);
      send_item(CH_QUOTE, 1'b0);
      send_item(",", 1'b1);
      // Empty tokens are now marked, including one ended by the final byte.
      send_item(",", 1'b0);
      send_item(",", 1'b0);
      send_item(";", 1'b1);
      send_item("z", 1'b1);

      // Random part: phases of random strings, each under its own settings.
      // About one string in ten is left open and runs into the next one.
      for (phase = 0; phase < PHASES; phase++) begin
         wait_idle();
         case (phase)
            0: apply_settings(3'd4, ",", ";", ":", "|", 1'b1, 1'b1);
            1: apply_settings(3'd0, " ", ",", 8'h09, ";", 1'b1, 1'b0);
            2: apply_settings(3'd7, random_delim(), random_delim(), random_delim(),
                              random_delim(), 1'b0, 1'b1);
            3: apply_settings(3'd2, 8'hFF, 8'h01, random_delim(), random_delim(),
                              1'b1, 1'b0);
            default: apply_settings(COUNT_W'($urandom_range(0, 7)), random_delim(),
                                    random_delim(), random_delim(), random_delim(),
                                    1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
         endcase
         // Phase two runs with no idling on either side; phase three carries the
         // long receiver hold-off while the sender keeps offering bytes.
         no_idle <= (phase == 2);
         if (phase == 3)
            hold_request <= 1'b1;
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            len = $urandom_range(1, 10);
            for (i = 0; i < len; i++)
               send_item(pick_byte(), (i == len - 1) && ($urandom_range(0, 9) != 0));
            sent += len;
         end
      end

      wait_idle();
      if (failures == 0)
         $display("tb_top: PASS");
      else
         $display("tb_top: FAIL");
      $finish;
   end

endmodule
